// ===== sv/bspg_pkg.sv =====
// Package for the Bezier segment point generator.
// Holds the state, operand and destination codes and the per-point multiply schedule.
// No dependencies; imported by bezier_segment_point_generator.
package bspg_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int DEGREE_W    = 2;
    localparam int STEPS_W     = 6;
    localparam int PHASE_W     = 2;
    localparam int SEQ_W       = 4;
    localparam int WIN_DEPTH   = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_CURVE_DEGREE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEPS        = 2'd1;

    localparam logic [DEGREE_W-1:0] DEGREE_RESET = 2'd2;
    localparam logic [DEGREE_W-1:0] DEGREE_MIN   = 2'd2;
    localparam logic [DEGREE_W-1:0] DEGREE_CUBIC = 2'd3;

    localparam logic [STEPS_W-1:0] STEPS_RESET   = 6'd5;
    localparam logic [STEPS_W-1:0] STEPS_DEFAULT = 6'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CALC,
        S_DRAIN,
        S_FIN
    } state_t;

    // Weight-side multiplier operand (unsigned).
    typedef enum logic [3:0] {
        A_U, A_T, A_UU, A_TT, A_TU, A_TU2, A_W0, A_W1, A_W2, A_W3
    } a_sel_t;

    // Signed multiplier operand: a curve parameter or a window coordinate.
    typedef enum logic [3:0] {
        B_U, B_T, B_X0, B_X1, B_X2, B_X3, B_Y0, B_Y1, B_Y2, B_Y3
    } b_sel_t;

    // Where a product goes. D_W1 and D_W2 store three times the rounded product.
    typedef enum logic [3:0] {
        D_NONE, D_UU, D_TT, D_TU, D_W0, D_W1, D_W2, D_W3, D_AX, D_AY
    } dst_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        dst_t   dst;
        logic   last;
    } seq_op_t;

    function automatic seq_op_t mk_op(input a_sel_t a, input b_sel_t b, input dst_t d,
                                      input logic l);
        seq_op_t op;
        op.a_sel = a;
        op.b_sel = b;
        op.dst   = d;
        op.last  = l;
        return op;
    endfunction

    // One multiply per step. A product is written back in the cycle after issue, so
    // no step reads a value produced by the step just before it.
    function automatic seq_op_t seq_op(input logic cubic, input logic [SEQ_W-1:0] step);
        seq_op_t op;
        op = mk_op(A_U, B_U, D_NONE, 1'b1);
        if (cubic) begin
            case (step)
                0:       op = mk_op(A_U,  B_U,  D_UU, 1'b0);
                1:       op = mk_op(A_T,  B_T,  D_TT, 1'b0);
                2:       op = mk_op(A_T,  B_U,  D_TU, 1'b0);
                3:       op = mk_op(A_UU, B_U,  D_W0, 1'b0);
                4:       op = mk_op(A_TU, B_U,  D_W1, 1'b0);
                5:       op = mk_op(A_TU, B_T,  D_W2, 1'b0);
                6:       op = mk_op(A_TT, B_T,  D_W3, 1'b0);
                7:       op = mk_op(A_W0, B_X0, D_AX, 1'b0);
                8:       op = mk_op(A_W0, B_Y0, D_AY, 1'b0);
                9:       op = mk_op(A_W1, B_X1, D_AX, 1'b0);
                10:      op = mk_op(A_W1, B_Y1, D_AY, 1'b0);
                11:      op = mk_op(A_W2, B_X2, D_AX, 1'b0);
                12:      op = mk_op(A_W2, B_Y2, D_AY, 1'b0);
                13:      op = mk_op(A_W3, B_X3, D_AX, 1'b0);
                14:      op = mk_op(A_W3, B_Y3, D_AY, 1'b1);
                default: op = mk_op(A_U,  B_U,  D_NONE, 1'b1);
            endcase
        end else begin
            case (step)
                0:       op = mk_op(A_U,   B_U,  D_UU, 1'b0);
                1:       op = mk_op(A_T,   B_T,  D_TT, 1'b0);
                2:       op = mk_op(A_T,   B_U,  D_TU, 1'b0);
                3:       op = mk_op(A_UU,  B_X1, D_AX, 1'b0);
                4:       op = mk_op(A_UU,  B_Y1, D_AY, 1'b0);
                5:       op = mk_op(A_TU2, B_X2, D_AX, 1'b0);
                6:       op = mk_op(A_TU2, B_Y2, D_AY, 1'b0);
                7:       op = mk_op(A_TT,  B_X3, D_AX, 1'b0);
                8:       op = mk_op(A_TT,  B_Y3, D_AY, 1'b1);
                default: op = mk_op(A_U,   B_U,  D_NONE, 1'b1);
            endcase
        end
        return op;
    endfunction

endpackage

// ===== sv/bezier_segment_point_generator.sv =====
// Bezier segment point generator: top level with sequencer, shared multiplier and output register.
// Depends on bspg_pkg for state and operand codes and the multiply schedule.
//
//   channel   | direction | handshake                  | payload
//   ----------+-----------+----------------------------+----------------------------------
//   point     | in        | point_valid / point_ready  | point_x, point_y
//   curve     | out       | curve_valid / curve_ready  | curve_x, curve_y, last_of_segment
//   cfg       | in        | cfg_write_en (no wait)     | cfg_index, cfg_data
//
// A control point that does not close a segment is simply taken into the window. A closing
// point starts a restoring divide of 2^T_FRAC_BITS by the step count, one quotient bit a cycle.
// Each curve point then runs 9 (quadratic) or 15 (cubic) multiplies on the single
// multiplier, followed by a drain state and a finishing state.
// Reset clears the window, phase and all handshake state and restores the configuration at once.
// point_ready is low while a segment is being evaluated; a full output register holds the
// sequencer in its finishing cycle until curve_ready takes the waiting transfer.
module bezier_segment_point_generator
    import bspg_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int MAX_STEPS   = 63,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write_en,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,

    input  logic                          point_valid,
    output logic                          point_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,

    output logic                          curve_valid,
    input  logic                          curve_ready,
    output logic signed [COORD_WIDTH-1:0] curve_x,
    output logic signed [COORD_WIDTH-1:0] curve_y,
    output logic                          last_of_segment
);

    // Curve parameter t, u and their products have T_FRAC_BITS fraction bits and reach 1.0.
    localparam int F      = T_FRAC_BITS;
    localparam int TW     = F + 1;
    localparam int WW     = F + 2;
    localparam int AW     = WW + 1;
    localparam int BW     = (COORD_WIDTH > F + 2) ? COORD_WIDTH : F + 2;
    localparam int PW     = AW + BW;
    localparam int ACC_W  = COORD_WIDTH + F + 4;
    localparam int N_W    = $clog2(MAX_STEPS + 1);
    localparam int R_W    = N_W + 1;
    localparam int DCNT_W = $clog2(F + 1);

    localparam logic [TW-1:0]           T_ONE    = {1'b1, {F{1'b0}}};
    localparam logic [PW-1:0]           P_HALF   = {{(PW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_HALF = {{(ACC_W - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0] COORD_MAX =
        {{(ACC_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] COORD_MIN =
        {{(ACC_W - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};
    localparam logic [STEPS_W-1:0]      STEPS_MAX = STEPS_W'(MAX_STEPS);
    localparam logic [DCNT_W-1:0]       DCNT_TOP  = DCNT_W'(F);

    // Control state.
    state_t                 state_reg, state_next;
    logic [DEGREE_W-1:0]    degree_reg, degree_next;
    logic [STEPS_W-1:0]     steps_reg, steps_next;
    logic                   primed_reg, primed_next;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [N_W-1:0]         k_reg, k_next;
    logic [SEQ_W-1:0]       step_reg, step_next;
    logic [DCNT_W-1:0]      dcnt_reg, dcnt_next;
    dst_t                   dst_reg, dst_next;
    logic                   out_valid_reg, out_valid_next;

    // Control-point window; the newest point sits at the highest index.
    logic signed [COORD_WIDTH-1:0] win_x_reg [WIN_DEPTH];
    logic signed [COORD_WIDTH-1:0] win_x_next [WIN_DEPTH];
    logic signed [COORD_WIDTH-1:0] win_y_reg [WIN_DEPTH];
    logic signed [COORD_WIDTH-1:0] win_y_next [WIN_DEPTH];

    // Datapath.
    logic [N_W-1:0]         n_reg, n_next;
    logic                   cubic_reg, cubic_next;
    logic [TW-1:0]          quot_reg, quot_next;
    logic [N_W-1:0]         rem_reg, rem_next;
    logic [N_W-1:0]         trem_reg, trem_next;
    logic [TW-1:0]          t_reg, t_next;
    logic [TW-1:0]          uu_reg, uu_next;
    logic [TW-1:0]          tt_reg, tt_next;
    logic [TW-1:0]          tu_reg, tu_next;
    logic [WW-1:0]          w_reg [WIN_DEPTH];
    logic [WW-1:0]          w_next [WIN_DEPTH];
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_x_reg, acc_x_next;
    logic signed [ACC_W-1:0] acc_y_reg, acc_y_next;
    logic signed [COORD_WIDTH-1:0] cx_reg, cx_next;
    logic signed [COORD_WIDTH-1:0] cy_reg, cy_next;
    logic                   last_reg, last_next;

    // Combinational helpers.
    seq_op_t                op_cur;
    logic [TW-1:0]          u_val;
    logic [WW-1:0]          a_val;
    logic signed [BW-1:0]   b_val;
    logic [PW-1:0]          rnd_sum;
    logic [PW-1:0]          rnd_val;
    logic [WW-1:0]          r_w;
    logic [WW-1:0]          r3_w;
    logic [STEPS_W-1:0]     steps_eff;
    logic [STEPS_W-1:0]     steps_clamped;
    logic [R_W-1:0]         div_shift;
    logic                   div_bit;
    logic [R_W-1:0]         tsum;
    logic                   tcarry;
    logic [PHASE_W:0]       phase_inc;
    logic                   in_xfer;
    logic                   out_free;
    logic signed [ACC_W-1:0] fin_x;
    logic signed [ACC_W-1:0] fin_y;

    function automatic logic signed [COORD_WIDTH-1:0] finish_coord(
        input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] v;
        logic signed [ACC_W-1:0] q;
        v = acc + ACC_HALF;
        q = v >>> F;
        if (q > COORD_MAX) begin
            q = COORD_MAX;
        end else if (q < COORD_MIN) begin
            q = COORD_MIN;
        end
        return q[COORD_WIDTH-1:0];
    endfunction

    assign point_ready     = (state_reg == S_IDLE);
    assign curve_valid     = out_valid_reg;
    assign curve_x         = cx_reg;
    assign curve_y         = cy_reg;
    assign last_of_segment = last_reg;

    assign in_xfer  = point_valid && point_ready;
    assign out_free = !out_valid_reg || curve_ready;
    assign op_cur   = seq_op(cubic_reg, step_reg);
    assign u_val    = T_ONE - t_reg;

    // Step count of zero falls back to the default, then saturates to the largest supported.
    assign steps_eff     = (steps_reg == '0) ? STEPS_DEFAULT : steps_reg;
    assign steps_clamped = (steps_eff > STEPS_MAX) ? STEPS_MAX : steps_eff;

    // Restoring divide of 2^F by n: the dividend has a single one at bit F.
    assign div_bit   = (dcnt_reg == DCNT_TOP);
    assign div_shift = {rem_reg, div_bit};

    // t advances by 2^F/n per point; the remainder carries the rounding exactly.
    assign tsum   = {1'b0, trem_reg} + {1'b0, rem_reg};
    assign tcarry = (tsum >= {1'b0, n_reg});

    assign phase_inc = {1'b0, phase_reg} + {{PHASE_W{1'b0}}, 1'b1};

    // Shared multiplier operand selection.
    always_comb
    begin
        case (op_cur.a_sel)
            A_U:     a_val = WW'(u_val);
            A_T:     a_val = WW'(t_reg);
            A_UU:    a_val = WW'(uu_reg);
            A_TT:    a_val = WW'(tt_reg);
            A_TU:    a_val = WW'(tu_reg);
            A_TU2:   a_val = {tu_reg, 1'b0};
            A_W0:    a_val = w_reg[0];
            A_W1:    a_val = w_reg[1];
            A_W2:    a_val = w_reg[2];
            A_W3:    a_val = w_reg[3];
            default: a_val = '0;
        endcase
        case (op_cur.b_sel)
            B_U:     b_val = $signed(BW'(u_val));
            B_T:     b_val = $signed(BW'(t_reg));
            B_X0:    b_val = BW'(win_x_reg[0]);
            B_X1:    b_val = BW'(win_x_reg[1]);
            B_X2:    b_val = BW'(win_x_reg[2]);
            B_X3:    b_val = BW'(win_x_reg[3]);
            B_Y0:    b_val = BW'(win_y_reg[0]);
            B_Y1:    b_val = BW'(win_y_reg[1]);
            B_Y2:    b_val = BW'(win_y_reg[2]);
            B_Y3:    b_val = BW'(win_y_reg[3]);
            default: b_val = '0;
        endcase
    end

    assign prod_next = $signed({1'b0, a_val}) * b_val;

    // Weight products are nonnegative and round half up at the fraction point.
    assign rnd_sum = $unsigned(prod_reg) + P_HALF;
    assign rnd_val = rnd_sum >> F;
    assign r_w     = rnd_val[WW-1:0];
    assign r3_w    = r_w + {r_w[WW-2:0], 1'b0};

    assign fin_x = acc_x_reg;
    assign fin_y = acc_y_reg;

    // Next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        degree_next    = degree_reg;
        steps_next     = steps_reg;
        primed_next    = primed_reg;
        phase_next     = phase_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        dcnt_next      = dcnt_reg;
        dst_next       = D_NONE;
        out_valid_next = out_valid_reg && !curve_ready;
        win_x_next     = win_x_reg;
        win_y_next     = win_y_reg;
        n_next         = n_reg;
        cubic_next     = cubic_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        trem_next      = trem_reg;
        t_next         = t_reg;
        uu_next        = uu_reg;
        tt_next        = tt_reg;
        tu_next        = tu_reg;
        w_next         = w_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        last_next      = last_reg;

        if (cfg_write_en) begin
            case (cfg_index)
                CFG_CURVE_DEGREE: degree_next = cfg_data[DEGREE_W-1:0];
                CFG_STEPS:        steps_next  = cfg_data[STEPS_W-1:0];
                default:          ;
            endcase
        end

        // Write-back of the product issued in the previous cycle.
        case (dst_reg)
            D_UU:    uu_next    = r_w[TW-1:0];
            D_TT:    tt_next    = r_w[TW-1:0];
            D_TU:    tu_next    = r_w[TW-1:0];
            D_W0:    w_next[0]  = r_w;
            D_W1:    w_next[1]  = r3_w;
            D_W2:    w_next[2]  = r3_w;
            D_W3:    w_next[3]  = r_w;
            D_AX:    acc_x_next = acc_x_reg + ACC_W'(prod_reg);
            D_AY:    acc_y_next = acc_y_reg + ACC_W'(prod_reg);
            default: ;
        endcase

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer) begin
                    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                        win_x_next[i] = win_x_reg[i + 1];
                        win_y_next[i] = win_y_reg[i + 1];
                    end
                    win_x_next[WIN_DEPTH - 1] = point_x;
                    win_y_next[WIN_DEPTH - 1] = point_y;
                    if (!primed_reg) begin
                        primed_next = 1'b1;
                        phase_next  = '0;
                    end else if (degree_reg >= DEGREE_MIN) begin
                        if (phase_inc >= {1'b0, degree_reg}) begin
                            phase_next = '0;
                            n_next     = steps_clamped[N_W-1:0];
                            cubic_next = (degree_reg == DEGREE_CUBIC);
                            dcnt_next  = DCNT_TOP;
                            rem_next   = '0;
                            quot_next  = '0;
                            state_next = S_DIV;
                        end else begin
                            phase_next = phase_inc[PHASE_W-1:0];
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_shift >= {1'b0, n_reg}) begin
                    rem_next  = N_W'(div_shift - {1'b0, n_reg});
                    quot_next = {quot_reg[TW-2:0], 1'b1};
                end else begin
                    rem_next  = div_shift[N_W-1:0];
                    quot_next = {quot_reg[TW-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == '0) begin
                    k_next     = '0;
                    t_next     = '0;
                    trem_next  = n_reg >> 1;
                    step_next  = '0;
                    acc_x_next = '0;
                    acc_y_next = '0;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                dst_next  = op_cur.dst;
                step_next = step_reg + SEQ_W'(1);
                if (op_cur.last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    cx_next        = finish_coord(fin_x);
                    cy_next        = finish_coord(fin_y);
                    last_next      = (k_reg == n_reg);
                    if (k_reg == n_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + N_W'(1);
                        t_next     = t_reg + quot_reg + TW'(tcarry);
                        trem_next  = tcarry ? N_W'(tsum - {1'b0, n_reg}) : tsum[N_W-1:0];
                        step_next  = '0;
                        acc_x_next = '0;
                        acc_y_next = '0;
                        state_next = S_CALC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            degree_reg    <= DEGREE_RESET;
            steps_reg     <= STEPS_RESET;
            primed_reg    <= 1'b0;
            phase_reg     <= '0;
            k_reg         <= '0;
            step_reg      <= '0;
            dcnt_reg      <= '0;
            dst_reg       <= D_NONE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WIN_DEPTH; i++) begin
                win_x_reg[i] <= '0;
                win_y_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            degree_reg    <= degree_next;
            steps_reg     <= steps_next;
            primed_reg    <= primed_next;
            phase_reg     <= phase_next;
            k_reg         <= k_next;
            step_reg      <= step_next;
            dcnt_reg      <= dcnt_next;
            dst_reg       <= dst_next;
            out_valid_reg <= out_valid_next;
            win_x_reg     <= win_x_next;
            win_y_reg     <= win_y_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        cubic_reg <= cubic_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        trem_reg  <= trem_next;
        t_reg     <= t_next;
        uu_reg    <= uu_next;
        tt_reg    <= tt_next;
        tu_reg    <= tu_next;
        w_reg     <= w_next;
        prod_reg  <= prod_next;
        acc_x_reg <= acc_x_next;
        acc_y_reg <= acc_y_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        last_reg  <= last_next;
    end

`ifndef ASSERT_OFF
    // The stepped parameter must land exactly on one at the closing point.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && k_reg == n_reg) |-> (t_reg == T_ONE))
        else $error("curve parameter does not reach one at the last point");

    // The rounding remainder stays below the step count while points are evaluated.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |-> (trem_reg < n_reg))
        else $error("parameter remainder out of range");

    // Products are written back only in the cycle after the sequencer issued them.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dst_reg != D_NONE) |-> $past(state_reg == S_CALC))
        else $error("product write-back without an issuing step");
`endif

endmodule

// ===== tb/bspg_curve_checker.sv =====
`timescale 1ns / 100ps
// Curve-point checker for the Bezier segment point generator testbench.
// Mirrors window, phase and configuration, predicts each curve point and compares transfers.
// Depends on bspg_pkg for register indexes, widths and reset values.
module bspg_curve_checker
    import bspg_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int MAX_STEPS   = 63,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          point_valid,
    input  logic                          point_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic                          curve_valid,
    input  logic                          curve_ready,
    input  logic signed [COORD_WIDTH-1:0] curve_x,
    input  logic signed [COORD_WIDTH-1:0] curve_y,
    input  logic                          last_of_segment,
    output int                            mismatch_count,
    output int                            points_due
);

    typedef struct {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic                          seg_end;
    } curve_point_t;

    curve_point_t                  due_points[$];
    curve_point_t                  head;
    logic signed [COORD_WIDTH-1:0] win_x [WIN_DEPTH];
    logic signed [COORD_WIDTH-1:0] win_y [WIN_DEPTH];
    logic [PHASE_W-1:0]            seg_phase;
    logic                          primed;
    logic [DEGREE_W-1:0]           degree;
    logic [STEPS_W-1:0]            steps;

    // Drop T_FRAC_BITS fraction bits, rounding half up.
    function automatic longint unsigned round_t(input longint unsigned v);
        return (v + (64'd1 << (T_FRAC_BITS - 1))) >> T_FRAC_BITS;
    endfunction

    // Round half toward +inf and saturate to the coordinate range.
    function automatic logic signed [COORD_WIDTH-1:0] settle_coord(input longint acc);
        longint q;
        longint hi;
        hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        q  = (acc + (longint'(1) <<< (T_FRAC_BITS - 1))) >>> T_FRAC_BITS;
        if (q > hi)
        begin
            q = hi;
        end
        if (q < -hi - 1)
        begin
            q = -hi - 1;
        end
        return q[COORD_WIDTH-1:0];
    endfunction

    function automatic void push_segment_points();
        longint unsigned one, t, u, uu, tt, tu, nn;
        longint          w [WIN_DEPTH];
        longint          ax, ay;
        int              n, base;
        curve_point_t    pt;
        one = 64'd1 << T_FRAC_BITS;
        n   = (steps == '0) ? int'(STEPS_DEFAULT) : int'(steps);
        if (n > MAX_STEPS)
        begin
            n = MAX_STEPS;
        end
        nn = n;
        for (int k = 0; k <= n; k++)
        begin
            t = k;
            t = ((t << T_FRAC_BITS) + nn / 2) / nn;
            if (t > one)
            begin
                t = one;
            end
            u  = one - t;
            uu = round_t(u * u);
            tt = round_t(t * t);
            tu = round_t(t * u);
            if (degree == DEGREE_CUBIC)
            begin
                w[0] = round_t(uu * u);
                w[1] = 3 * round_t(tu * u);
                w[2] = 3 * round_t(tu * t);
                w[3] = round_t(tt * t);
                base = 0;
            end
            else
            begin
                w[0] = uu;
                w[1] = 2 * tu;
                w[2] = tt;
                w[3] = 0;
                base = 1;
            end
            ax = 0;
            ay = 0;
            for (int j = 0; j + base < WIN_DEPTH; j++)
            begin
                ax += longint'(win_x[base + j]) * w[j];
                ay += longint'(win_y[base + j]) * w[j];
            end
            pt.x       = settle_coord(ax);
            pt.y       = settle_coord(ay);
            pt.seg_end = (k == n);
            due_points = {due_points, pt};
        end
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [COORD_WIDTH-1:0] want,
                                        input logic signed [COORD_WIDTH-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_x[i] = '0;
                win_y[i] = '0;
            end
            seg_phase      = '0;
            primed         = 1'b0;
            degree         = DEGREE_RESET;
            steps          = STEPS_RESET;
            mismatch_count = 0;
            due_points.delete();
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_CURVE_DEGREE: degree = cfg_data[DEGREE_W-1:0];
                    CFG_STEPS:        steps  = cfg_data[STEPS_W-1:0];
                    default:          ;
                endcase
            end
            if (curve_valid && curve_ready)
            begin
                if (due_points.size() == 0)
                begin
                    $display("%0t: unexpected curve point x %0d y %0d last %0b",
                             $time, curve_x, curve_y, last_of_segment);
                    mismatch_count++;
                end
                else
                begin
                    head = due_points[0];
                    due_points.delete(0);
                    check_field("curve_x", head.x, curve_x);
                    check_field("curve_y", head.y, curve_y);
                    check_field("last_of_segment", COORD_WIDTH'(head.seg_end),
                                COORD_WIDTH'(last_of_segment));
                end
            end
            if (point_valid && point_ready)
            begin
                for (int i = 0; i < WIN_DEPTH - 1; i++)
                begin
                    win_x[i] = win_x[i + 1];
                    win_y[i] = win_y[i + 1];
                end
                win_x[WIN_DEPTH-1] = point_x;
                win_y[WIN_DEPTH-1] = point_y;
                if (!primed)
                begin
                    primed    = 1'b1;
                    seg_phase = '0;
                end
                else if (degree >= DEGREE_MIN)
                begin
                    if (seg_phase + 1 >= degree)
                    begin
                        seg_phase = '0;
                        push_segment_points();
                    end
                    else
                    begin
                        seg_phase = seg_phase + 1'b1;
                    end
                end
            end
        end
        points_due = due_points.size();
    end

endmodule

// ===== tb/bezier_segment_point_generator_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for bezier_segment_point_generator: clock, reset, stimulus and verdict.
// Depends on bspg_pkg, the block under test and bspg_curve_checker, which does all checking.
module bezier_segment_point_generator_tb;
    import bspg_pkg::*;

    localparam int COORD_WIDTH = 24;
    localparam int MAX_STEPS   = 63;
    localparam int T_FRAC_BITS = 16;

    // Number of control points in the random part.
    localparam int RANDOM_POINTS = 500;
    // Cycles allowed after the last result so the block is surely back in idle.
    localparam int SETTLE_CYCLES = 40;
    // Length of the one long receiver hold-off that backs the block up.
    localparam int LONG_HOLD_CYCLES = 400;

    // Degree codes the block does not support; points still enter the window.
    localparam logic [DEGREE_W-1:0] DEGREE_NONE = 2'd0;
    localparam logic [DEGREE_W-1:0] DEGREE_LINE = 2'd1;
    localparam logic [STEPS_W-1:0]  STEPS_TOP   = 6'd63;

    // Register indexes that decode to nothing; writes to them must be dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write_en;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          point_valid;
    logic                          point_ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          curve_valid;
    logic                          curve_ready;
    logic signed [COORD_WIDTH-1:0] curve_x;
    logic signed [COORD_WIDTH-1:0] curve_y;
    logic                          last_of_segment;

    int   mismatch_count;
    int   points_due;

    // Idle modes for the current phase, and the request for the one long hold-off.
    logic src_idle;
    logic sink_idle;
    logic long_hold_req;

    bezier_segment_point_generator #(
        .COORD_WIDTH (COORD_WIDTH),
        .MAX_STEPS   (MAX_STEPS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .point_valid     (point_valid),
        .point_ready     (point_ready),
        .point_x         (point_x),
        .point_y         (point_y),
        .curve_valid     (curve_valid),
        .curve_ready     (curve_ready),
        .curve_x         (curve_x),
        .curve_y         (curve_y),
        .last_of_segment (last_of_segment)
    );

    // The checker watches every channel on the rising edge and keeps the failure count.
    bspg_curve_checker #(
        .COORD_WIDTH (COORD_WIDTH),
        .MAX_STEPS   (MAX_STEPS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) curve_watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .point_valid     (point_valid),
        .point_ready     (point_ready),
        .point_x         (point_x),
        .point_y         (point_y),
        .curve_valid     (curve_valid),
        .curve_ready     (curve_ready),
        .curve_x         (curve_x),
        .curve_y         (curve_y),
        .last_of_segment (last_of_segment),
        .mismatch_count  (mismatch_count),
        .points_due      (points_due)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // A register write raises the enable for a single cycle; the enable then drops again so that two
    // writes in a row never touch the enable twice in one time step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // The degree lives in the low bits of the write data; the bits above it are random
    // so that a block decoding them would be caught.
    task automatic set_curve(input logic [DEGREE_W-1:0] deg, input logic [STEPS_W-1:0] stp);
        logic [CFG_DATA_W-1:0] data;
        data               = CFG_DATA_W'($urandom);
        data[DEGREE_W-1:0] = deg;
        write_reg(CFG_CURVE_DEGREE, data);
        write_reg(CFG_STEPS, stp);
    endtask

    // Called and left at a falling edge. With no gap, valid simply stays high and only
    // the payload moves on to the next point.
    task automatic send_point(input logic signed [COORD_WIDTH-1:0] x,
                              input logic signed [COORD_WIDTH-1:0] y,
                              input int gap);
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        point_valid <= 1'b1;
        point_x     <= x;
        point_y     <= y;
        do @(posedge clk); while (!(point_valid && point_ready));
        @(negedge clk);
    endtask

    // Stop offering points and wait until every predicted curve point has been taken.
    // A point that closes no segment leaves nothing to wait on, so a settling stretch
    // follows before anything touches the registers.
    task automatic drain();
        point_valid <= 1'b0;
        while (points_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly full-range coordinates, with a share of extremes and of small values around
    // zero so that rounding near zero gets exercised.
    function automatic logic signed [COORD_WIDTH-1:0] draw_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2, 3:    return COORD_WIDTH'(int'($urandom_range(0, 1023)) - 512);
            default: return COORD_WIDTH'($urandom);
        endcase
    endfunction

    // Receiver: a fresh hold-off for every transfer, or the long one once when asked for.
    initial
    begin : sink
        int   hold;
        logic long_hold_taken;
        curve_ready     = 1'b0;
        long_hold_taken = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold_req && !long_hold_taken)
            begin
                hold            = LONG_HOLD_CYCLES;
                long_hold_taken = 1'b1;
            end
            else
            begin
                hold = sink_idle ? $urandom_range(0, 19) : 0;
            end
            if (hold > 0)
            begin
                curve_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            curve_ready <= 1'b1;
            do @(posedge clk); while (!(curve_valid && curve_ready));
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int                  sent;
        int                  phase_no;
        int                  phase_len;
        logic [DEGREE_W-1:0] deg;
        logic [STEPS_W-1:0]  stp;

        rst_n         = 1'b0;
        cfg_write_en  = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        point_valid   = 1'b0;
        point_x       = '0;
        point_y       = '0;
        src_idle      = 1'b0;
        sink_idle     = 1'b0;
        long_hold_req = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: quadratic, five intervals. The first point only primes
        // the window; the third closes the first segment.
        send_point(COORD_MAX, COORD_MIN, 0);
        send_point(COORD_MIN, COORD_MAX, 0);
        send_point('0, '1, 0);
        drain();

        // Cubic with a zero step count, which falls back to the default. Full-scale
        // corners push the weighted sum to the saturation limits.
        set_curve(DEGREE_CUBIC, '0);
        send_point(COORD_MAX, COORD_MAX, 0);
        send_point(COORD_MIN, COORD_MIN, 0);
        send_point(COORD_MAX, COORD_MIN, 0);
        drain();

        // A single interval: only the two end points come out.
        set_curve(DEGREE_MIN, 6'd1);
        send_point('1, 24'sd1, 0);
        send_point(24'sd1, '1, 0);
        drain();

        // Unsupported degrees emit nothing but keep shifting the window.
        set_curve(DEGREE_NONE, STEPS_TOP);
        send_point(draw_coord(), draw_coord(), 0);
        send_point(draw_coord(), draw_coord(), 0);
        drain();
        set_curve(DEGREE_LINE, STEPS_TOP);
        send_point(draw_coord(), draw_coord(), 0);
        send_point(draw_coord(), draw_coord(), 0);
        drain();

        // Degree lowered in the middle of a cubic segment: the next point closes it at
        // once, here with the largest step count.
        set_curve(DEGREE_CUBIC, STEPS_TOP);
        send_point(draw_coord(), draw_coord(), 0);
        send_point(draw_coord(), draw_coord(), 0);
        drain();
        set_curve(DEGREE_MIN, STEPS_TOP);
        send_point(draw_coord(), draw_coord(), 0);
        drain();

        // Writes to indexes that decode to nothing must leave the settings alone.
        set_curve(DEGREE_MIN, 6'd2);
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
        send_point(draw_coord(), draw_coord(), 0);
        send_point(draw_coord(), draw_coord(), 0);
        drain();

        // Random phases. Each starts idle with new settings and its own idle mode, and
        // its length is random so the degree often changes in mid-segment.
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_POINTS)
        begin
            drain();
            case ($urandom_range(0, 9))
                0:          deg = ($urandom_range(0, 1) == 0) ? DEGREE_NONE : DEGREE_LINE;
                1, 2, 3, 4: deg = DEGREE_MIN;
                default:    deg = DEGREE_CUBIC;
            endcase
            case ($urandom_range(0, 9))
                0:       stp = '0;
                1:       stp = 6'd1;
                2:       stp = STEPS_TOP;
                default: stp = STEPS_W'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 3))
                0:
                begin
                    src_idle  = 1'b0;
                    sink_idle = 1'b0;
                end
                1:
                begin
                    src_idle  = 1'b1;
                    sink_idle = 1'b1;
                end
                2:
                begin
                    src_idle  = 1'b1;
                    sink_idle = 1'b0;
                end
                default:
                begin
                    src_idle  = 1'b0;
                    sink_idle = 1'b1;
                end
            endcase
            // In one phase the receiver stops for a long stretch while points keep
            // coming, so the output register fills and point_ready stays low.
            if (phase_no == 2)
            begin
                deg           = DEGREE_MIN;
                stp           = 6'd8;
                src_idle      = 1'b0;
                long_hold_req = 1'b1;
            end
            set_curve(deg, stp);
            phase_len = $urandom_range(4, 30);
            for (int i = 0; i < phase_len; i++)
            begin
                // Now and then the sender pauses until everything due has arrived.
                if ((phase_no == 1 && i == phase_len / 2) || $urandom_range(0, 49) == 0)
                begin
                    drain();
                end
                send_point(draw_coord(), draw_coord(), src_idle ? $urandom_range(0, 19) : 0);
            end
            sent += phase_len;
            phase_no++;
        end
        drain();

        if (mismatch_count == 0 && points_due == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Run limit: a few times the slowest legal run, with every segment at 64 points and
    // every transfer held off for the longest draw.
    initial
    begin : watchdog
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bspg_pkg.sv
sv/bezier_segment_point_generator.sv
tb/bspg_curve_checker.sv
tb/bezier_segment_point_generator_tb.sv
